// ===== rtl/core/llca_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// llca_pkg: shared types and constants for the cell step block
// Grid geometry, register indexes, neighbour offsets and the state encoding.
// ============================================================================
package llca_pkg;

    // Grid geometry
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ADDR_W   = ROW_W + COL_W;
    localparam int SIZE_W   = 7;

    // Configuration registers
    localparam int RULE_W   = 18;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 18;

    localparam logic [CFG_IDX_W-1:0] REG_RULE_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd2;

    localparam logic [RULE_W-1:0] RULE_RESET = 18'd6152;
    localparam logic [SIZE_W-1:0] ROWS_RESET = SIZE_W'(MAX_ROWS);
    localparam logic [SIZE_W-1:0] COLS_RESET = SIZE_W'(MAX_COLS);

    // Sequencer steps: eight neighbours, then the cell itself
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_SELF = 4'd8;
    localparam int CNT_W  = 4;
    localparam int IDX_W  = 5;
    localparam logic [IDX_W-1:0] SURVIVE_BASE = 5'd9;

    localparam logic [7:0] SHADE_ALIVE = 8'hFF;
    localparam logic [7:0] SHADE_DEAD  = 8'h00;

    typedef enum logic [0:0] {
        FUNC_LOAD = 1'b0,
        FUNC_EVAL = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        D_DEC,
        D_HOLD,
        D_INC
    } t_delta;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_READ,
        S_DRAIN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic              data;
    } t_mem_wr;

    // Row offset of each neighbour position
    function automatic t_delta nb_row_delta(input logic [STEP_W-1:0] step);
        t_delta d;
        case (step)
            4'd0, 4'd1, 4'd2: d = D_DEC;
            4'd5, 4'd6, 4'd7: d = D_INC;
            default:          d = D_HOLD;
        endcase
        return d;
    endfunction

    // Column offset of each neighbour position
    function automatic t_delta nb_col_delta(input logic [STEP_W-1:0] step);
        t_delta d;
        case (step)
            4'd0, 4'd3, 4'd5: d = D_DEC;
            4'd2, 4'd4, 4'd7: d = D_INC;
            default:          d = D_HOLD;
        endcase
        return d;
    endfunction

    // Size register in effect: zero acts as one, large values saturate
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] lim);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > lim) begin
            r = lim;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/life_like_automaton_cell_step.sv =====
`timescale 1ns / 1ps
// ============================================================================
// life_like_automaton_cell_step: life-like automaton cell evaluator
// Keeps a toroidal one-bit grid; loads cells and evaluates one cell's next
// state from its eight neighbours and an 18-bit birth/survival rule.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+-------------------------------
//   command  | start / busy                 | i_func, i_row, i_col, i_red,
//            |                              | i_green, i_blue
//   result   | o_strobe (one-cycle pulse)   | o_shade, o_next_alive,
//            |                              | o_bad_address
//   config   | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// A load inside the grid writes its cell and gives no result word. An
// address outside the grid gives its flagged word, with the state register
// and the strobe register between start and the word. An evaluate gives
// its result word after a decode step, nine reads through the single read
// port of the cell memory, the registered read of the memory, a rule test
// and the result register. Busy is high from the cycle after start until
// the block is idle again. Reset is synchronous and active low; the memory
// is not cleared. The receiver cannot stall the result.
// ============================================================================
module life_like_automaton_cell_step (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Command channel
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_func,
    input  logic [5:0]                       i_row,
    input  logic [5:0]                       i_col,
    input  logic [7:0]                       i_red,
    input  logic [7:0]                       i_green,
    input  logic [7:0]                       i_blue,
    // Result channel
    output logic                             o_strobe,
    output logic [7:0]                       o_shade,
    output logic                             o_next_alive,
    output logic                             o_bad_address,
    // Configuration channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [llca_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [llca_pkg::CFG_W-1:0]       i_cfg_data
);

    // Configuration registers
    logic [llca_pkg::RULE_W-1:0] r_rule;
    logic [llca_pkg::SIZE_W-1:0] r_rows_cfg;
    logic [llca_pkg::SIZE_W-1:0] r_cols_cfg;

    // Sequencer state
    llca_pkg::t_state r_state, n_state;
    logic [llca_pkg::STEP_W-1:0] r_step, n_step;
    logic                        r_rd_vld, n_rd_vld;
    logic                        r_rd_self, n_rd_self;
    logic [llca_pkg::CNT_W-1:0]  r_count, n_count;
    logic                        r_alive, n_alive;

    // Latched command word
    logic                        r_func;
    logic [llca_pkg::ROW_W-1:0]  r_row;
    logic [llca_pkg::COL_W-1:0]  r_col;
    logic                        r_pix_alive;

    // Result registers
    logic                        r_strobe, n_strobe;
    logic [7:0]                  r_shade, n_shade;
    logic                        r_next_alive, n_next_alive;
    logic                        r_bad, n_bad;

    logic [llca_pkg::SIZE_W-1:0] rows_eff;
    logic [llca_pkg::SIZE_W-1:0] cols_eff;
    logic                        addr_bad;
    logic [llca_pkg::ADDR_W-1:0] rd_addr;
    logic                        rd_data;
    llca_pkg::t_mem_wr           mem_wr;
    logic [llca_pkg::IDX_W-1:0]  rule_idx;
    logic                        accept;

    assign accept      = start && !busy;
    assign busy        = (r_state != llca_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule     <= llca_pkg::RULE_RESET;
            r_rows_cfg <= llca_pkg::ROWS_RESET;
            r_cols_cfg <= llca_pkg::COLS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                llca_pkg::REG_RULE_MASK: r_rule <= i_cfg_data[llca_pkg::RULE_W-1:0];
                llca_pkg::REG_GRID_ROWS: r_rows_cfg <= i_cfg_data[llca_pkg::SIZE_W-1:0];
                llca_pkg::REG_GRID_COLS: r_cols_cfg <= i_cfg_data[llca_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Sizes in effect and the out-of-grid check
    assign rows_eff = llca_pkg::clamp_size(r_rows_cfg, llca_pkg::SIZE_W'(llca_pkg::MAX_ROWS));
    assign cols_eff = llca_pkg::clamp_size(r_cols_cfg, llca_pkg::SIZE_W'(llca_pkg::MAX_COLS));
    assign addr_bad = (llca_pkg::SIZE_W'(r_row) >= rows_eff) ||
                      (llca_pkg::SIZE_W'(r_col) >= cols_eff);

    // Command word capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func      <= i_func;
            r_row       <= i_row;
            r_col       <= i_col;
            r_pix_alive <= (i_red == 8'hFF) && (i_green == 8'hFF) && (i_blue == 8'hFF);
        end
    end

    // Shared neighbour address unit
    llca_addr_gen u_addr_gen (
        .i_step (r_step),
        .i_row  (r_row),
        .i_col  (r_col),
        .i_rows (rows_eff),
        .i_cols (cols_eff),
        .o_addr (rd_addr)
    );

    // Cell store
    llca_cell_mem u_cell_mem (
        .i_clk   (i_clk),
        .i_wr    (mem_wr),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Rule bit index: survival bits sit above the birth bits
    assign rule_idx = r_alive ? (llca_pkg::IDX_W'(r_count) + llca_pkg::SURVIVE_BASE)
                              : llca_pkg::IDX_W'(r_count);

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= llca_pkg::S_IDLE;
            r_step   <= '0;
            r_rd_vld <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_rd_vld <= n_rd_vld;
            r_strobe <= n_strobe;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_rd_self    <= n_rd_self;
        r_count      <= n_count;
        r_alive      <= n_alive;
        r_shade      <= n_shade;
        r_next_alive <= n_next_alive;
        r_bad        <= n_bad;
    end

    // Next state and outputs
    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_rd_vld     = 1'b0;
        n_rd_self    = r_rd_self;
        n_count      = r_count;
        n_alive      = r_alive;
        n_strobe     = 1'b0;
        n_shade      = r_shade;
        n_next_alive = r_next_alive;
        n_bad        = r_bad;
        mem_wr.en    = 1'b0;
        mem_wr.addr  = {r_row, r_col};
        mem_wr.data  = r_pix_alive;

        // Gather read data in the cycle after its address
        if (r_rd_vld) begin
            if (r_rd_self) begin
                n_alive = rd_data;
            end else begin
                n_count = r_count + llca_pkg::CNT_W'(rd_data);
            end
        end

        unique case (r_state)
            llca_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = llca_pkg::S_DECIDE;
                end
            end
            llca_pkg::S_DECIDE: begin
                n_step  = '0;
                n_count = '0;
                n_alive = 1'b0;
                if (addr_bad) begin
                    n_strobe     = 1'b1;
                    n_shade      = llca_pkg::SHADE_DEAD;
                    n_next_alive = 1'b0;
                    n_bad        = 1'b1;
                    n_state      = llca_pkg::S_IDLE;
                end else if (r_func == llca_pkg::FUNC_LOAD) begin
                    mem_wr.en = 1'b1;
                    n_state   = llca_pkg::S_IDLE;
                end else begin
                    n_state = llca_pkg::S_READ;
                end
            end
            llca_pkg::S_READ: begin
                n_rd_vld  = 1'b1;
                n_rd_self = (r_step == llca_pkg::STEP_SELF);
                if (r_step == llca_pkg::STEP_SELF) begin
                    n_state = llca_pkg::S_DRAIN;
                end else begin
                    n_step = r_step + llca_pkg::STEP_W'(1);
                end
            end
            llca_pkg::S_DRAIN: begin
                n_state = llca_pkg::S_FINISH;
            end
            llca_pkg::S_FINISH: begin
                n_strobe     = 1'b1;
                n_next_alive = r_rule[rule_idx];
                n_shade      = r_rule[rule_idx] ? llca_pkg::SHADE_ALIVE
                                                : llca_pkg::SHADE_DEAD;
                n_bad        = 1'b0;
                n_state      = llca_pkg::S_IDLE;
            end
            default: begin
                n_state = llca_pkg::S_IDLE;
            end
        endcase
    end

    assign o_strobe      = r_strobe;
    assign o_shade       = r_shade;
    assign o_next_alive  = r_next_alive;
    assign o_bad_address = r_bad;

`ifndef SYNTH
    // A result word lasts exactly one cycle.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for more than one cycle");

    // A flagged word reports a dead cell.
    a_bad_dead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_bad_address) |-> (!o_next_alive && (o_shade == llca_pkg::SHADE_DEAD)))
        else $error("flagged result reports a live cell");

    // Shade agrees with the next-state bit.
    a_shade_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((o_shade == llca_pkg::SHADE_ALIVE) == o_next_alive))
        else $error("shade disagrees with next state");

    // The step counter never runs past the cell itself.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == llca_pkg::S_READ) |-> (r_step <= llca_pkg::STEP_SELF))
        else $error("read step out of range");

    // The rule test follows the last read, with the drain state between them.
    a_finish_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == llca_pkg::S_FINISH) |-> ($past(r_state) == llca_pkg::S_DRAIN))
        else $error("rule test entered without draining the read");
`endif

endmodule

// ===== rtl/core/llca_addr_gen.sv =====
`timescale 1ns / 1ps
// ============================================================================
// llca_addr_gen: toroidal neighbour address unit
// Forms the memory address of one neighbour (or the cell itself) per step,
// wrapping row and column at the sizes in effect.
// ============================================================================
module llca_addr_gen (
    input  logic [llca_pkg::STEP_W-1:0] i_step,
    input  logic [llca_pkg::ROW_W-1:0]  i_row,
    input  logic [llca_pkg::COL_W-1:0]  i_col,
    input  logic [llca_pkg::SIZE_W-1:0] i_rows,
    input  logic [llca_pkg::SIZE_W-1:0] i_cols,
    output logic [llca_pkg::ADDR_W-1:0] o_addr
);

    logic [llca_pkg::ROW_W-1:0] row_w;
    logic [llca_pkg::COL_W-1:0] col_w;
    logic [llca_pkg::SIZE_W-1:0] row_inc;
    logic [llca_pkg::SIZE_W-1:0] col_inc;

    assign row_inc = llca_pkg::SIZE_W'(i_row) + llca_pkg::SIZE_W'(1);
    assign col_inc = llca_pkg::SIZE_W'(i_col) + llca_pkg::SIZE_W'(1);

    // Row wrap: step back to the last row, or forward to row zero
    always_comb begin
        unique case (llca_pkg::nb_row_delta(i_step))
            llca_pkg::D_DEC: begin
                if (i_row == '0) begin
                    row_w = llca_pkg::ROW_W'(i_rows - llca_pkg::SIZE_W'(1));
                end else begin
                    row_w = i_row - llca_pkg::ROW_W'(1);
                end
            end
            llca_pkg::D_INC: begin
                if (row_inc >= i_rows) begin
                    row_w = '0;
                end else begin
                    row_w = llca_pkg::ROW_W'(row_inc);
                end
            end
            default: row_w = i_row;
        endcase
    end

    // Column wrap, same scheme
    always_comb begin
        unique case (llca_pkg::nb_col_delta(i_step))
            llca_pkg::D_DEC: begin
                if (i_col == '0) begin
                    col_w = llca_pkg::COL_W'(i_cols - llca_pkg::SIZE_W'(1));
                end else begin
                    col_w = i_col - llca_pkg::COL_W'(1);
                end
            end
            llca_pkg::D_INC: begin
                if (col_inc >= i_cols) begin
                    col_w = '0;
                end else begin
                    col_w = llca_pkg::COL_W'(col_inc);
                end
            end
            default: col_w = i_col;
        endcase
    end

    assign o_addr = {row_w, col_w};

endmodule

// ===== rtl/core/llca_cell_mem.sv =====
`timescale 1ns / 1ps
// ============================================================================
// llca_cell_mem: one-bit cell store
// One write port and one read port with registered read data.
// ============================================================================
module llca_cell_mem (
    input  logic                        i_clk,
    input  llca_pkg::t_mem_wr           i_wr,
    input  logic [llca_pkg::ADDR_W-1:0] i_raddr,
    output logic                        o_rdata
);

    logic r_mem [0:(1 << llca_pkg::ADDR_W)-1];
    logic r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
